// File: rtl/core/gup2x_pkg.sv
// shared widths, types and codes for the 2x midpoint grid upsampler
package gup2x_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int DIM_W     = 11;
	localparam int IDX_W     = 11;
	localparam int CFG_IDX_W = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIM_W-1:0]              dim_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [ROW_W-1:0]              row_t;
	typedef logic [COL_W-1:0]              col_t;
	typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

	localparam cfg_idx_t REG_SOURCE_ROWS = CFG_IDX_W'(0);
	localparam cfg_idx_t REG_SOURCE_COLS = CFG_IDX_W'(1);

	// output points of one item, in emission order
	typedef enum logic [1:0] {
		PT_CENTRE,
		PT_VERT,
		PT_HORIZ,
		PT_COPY
	} point_kind_t;

	// one source sample with its grid position
	typedef struct packed {
		row_t    row;
		col_t    col;
		sample_t cur;
		logic    endg;
	} job_t;

endpackage

// File: rtl/core/gup2x_ifs.sv
// stream interfaces: source samples, output points, configuration writes
interface gup2x_in_if;
	logic                 valid;
	logic                 ready;
	gup2x_pkg::sample_t   sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface gup2x_out_if;
	logic                 valid;
	logic                 ready;
	gup2x_pkg::idx_t      out_row;
	gup2x_pkg::idx_t      out_col;
	gup2x_pkg::sample_t   value;
	logic                 last_of_run;
	logic                 end_of_grid;

	modport source (output valid, output out_row, output out_col, output value,
		output last_of_run, output end_of_grid, input ready);
	modport sink   (input valid, input out_row, input out_col, input value,
		input last_of_run, input end_of_grid, output ready);
endinterface

interface gup2x_cfg_if;
	logic                 valid;
	logic                 ready;
	gup2x_pkg::cfg_idx_t  index;
	gup2x_pkg::dim_t      data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/grid_upsample_2x_midpoint.sv
// top level: 2x midpoint upsampler of a streamed source grid
//
//  channel   role     handshake      payload
//  samples   sink     valid/ready    sample
//  points    source   valid/ready    out_row, out_col, value, last_of_run, end_of_grid
//  cfg       sink     valid/ready    index, data (always ready)
//
// an item gives 1 point on row 0 column 0, 2 on row 0 or column 0, 4 elsewhere:
// the point emitter sends one point per cycle while points is ready, and sets the rate
// from sample accept to first point: line store read with the sample stage, then point stage
// a new sample is taken while the points of the previous one are still going out
// arst_n clears counters, valid flags and left neighbors; the line store is not cleared
// a stall on points holds the current point and backs up into samples
module grid_upsample_2x_midpoint (
	input  logic        clk,
	input  logic        arst_n,
	gup2x_in_if.sink    samples,
	gup2x_out_if.source points,
	gup2x_cfg_if.sink   cfg
);
	import gup2x_pkg::*;

	// configuration registers
	dim_t rows_q;
	dim_t cols_q;

	// grid position of the next sample
	row_t row_q;
	col_t col_q;

	// sample stage: waits here while the line store read completes
	logic valid_s1;
	job_t job_s1;

	dim_t    nr;
	dim_t    nc;
	row_t    row_eff;
	col_t    col_eff;
	logic    at_last_col;
	logic    at_last_row;
	logic    in_take;
	logic    cfg_wr;
	logic    job_ready;
	sample_t above;

	// clamp a dimension register to 2..limit
	function automatic dim_t clamp_dim(input dim_t v, input dim_t limit);
		dim_t r;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (v > limit) begin
			r = limit;
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign nr = clamp_dim(rows_q, DIM_W'(MAX_ROWS));
	assign nc = clamp_dim(cols_q, DIM_W'(MAX_COLS));

	// out-of-range position restarts the grid
	always_comb begin
		if (DIM_W'(row_q) >= nr || DIM_W'(col_q) >= nc) begin
			row_eff = '0;
			col_eff = '0;
		end else begin
			row_eff = row_q;
			col_eff = col_q;
		end
	end

	assign at_last_col = (DIM_W'(col_eff) + DIM_W'(1)) >= nc;
	assign at_last_row = (DIM_W'(row_eff) + DIM_W'(1)) >= nr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	// sample stage empties whenever the emitter takes its job
	assign samples.ready = !valid_s1 || job_ready;
	assign in_take       = samples.valid && samples.ready;

	// config registers; any write inside the list restarts the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(5);
			cols_q <= DIM_W'(17);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_wr && (cfg.index == REG_SOURCE_ROWS || cfg.index == REG_SOURCE_COLS)) begin
			if (cfg.index == REG_SOURCE_ROWS) begin
				rows_q <= cfg.data;
			end else begin
				cols_q <= cfg.data;
			end
			row_q <= '0;
			col_q <= '0;
		end else if (in_take) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_last_row ? '0 : row_eff + ROW_W'(1);
			end else begin
				col_q <= col_eff + COL_W'(1);
				row_q <= row_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			job_s1.row  <= row_eff;
			job_s1.col  <= col_eff;
			job_s1.cur  <= samples.sample;
			job_s1.endg <= (DIM_W'(row_eff) == nr - DIM_W'(1)) &&
				(DIM_W'(col_eff) == nc - DIM_W'(1));
		end
	end

	// previous row: read the old entry and overwrite it with the new sample
	// in the same cycle, so reads and writes never collide
	gup2x_line_ram #(
		.DEPTH (MAX_COLS),
		.WIDTH (SAMPLE_BITS)
	) u_line_ram (
		.clk   (clk),
		.en    (in_take),
		.addr  (col_eff),
		.wdata (samples.sample),
		.rdata (above)
	);

	gup2x_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (valid_s1),
		.job_ready (job_ready),
		.job       (job_s1),
		.above     (above),
		.points    (points)
	);

endmodule

// File: rtl/core/gup2x_line_ram.sv
// single-port read-first line store with registered read data
module gup2x_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			rdata     <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

// File: rtl/core/gup2x_emit.sv
// point builder: averages one sample with its neighbors and emits up to four points
module gup2x_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  gup2x_pkg::job_t   job,
	input  gup2x_pkg::sample_t above,
	gup2x_out_if.source       points
);
	import gup2x_pkg::*;

	localparam int SUM4_W = SAMPLE_BITS + 2;
	localparam int SUM2_W = SAMPLE_BITS + 1;

	logic        busy_q;
	point_kind_t kind_q;
	sample_t     left_q;
	sample_t     left_above_q;

	row_t    row_s2;
	col_t    col_s2;
	logic    endg_s2;
	sample_t centre_s2;
	sample_t vert_s2;
	sample_t horiz_s2;
	sample_t copy_s2;

	logic signed [SUM4_W-1:0] sum4;
	logic signed [SUM2_W-1:0] sum_v;
	logic signed [SUM2_W-1:0] sum_h;
	point_kind_t first_kind;
	point_kind_t next_kind;
	logic        load;
	logic        take;
	idx_t        row_even;
	idx_t        col_even;

	assign sum4 = SUM4_W'(left_above_q) + SUM4_W'(above) + SUM4_W'(left_q) + SUM4_W'(job.cur);
	assign sum_v = SUM2_W'(above) + SUM2_W'(job.cur);
	assign sum_h = SUM2_W'(left_q) + SUM2_W'(job.cur);

	assign take      = points.valid && points.ready;
	assign job_ready = !busy_q || (take && kind_q == PT_COPY);
	assign load      = job_valid && job_ready;

	always_comb begin
		priority if (job.row != '0 && job.col != '0) begin
			first_kind = PT_CENTRE;
		end else if (job.row != '0) begin
			first_kind = PT_VERT;
		end else if (job.col != '0) begin
			first_kind = PT_HORIZ;
		end else begin
			first_kind = PT_COPY;
		end
	end

	always_comb begin
		unique case (kind_q)
			PT_CENTRE: next_kind = PT_VERT;
			PT_VERT:   next_kind = (col_s2 != '0) ? PT_HORIZ : PT_COPY;
			PT_HORIZ:  next_kind = PT_COPY;
			PT_COPY:   next_kind = PT_COPY;
			default:   next_kind = PT_COPY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			kind_q       <= PT_COPY;
			left_q       <= '0;
			left_above_q <= '0;
		end else if (load) begin
			busy_q       <= 1'b1;
			kind_q       <= first_kind;
			left_q       <= job.cur;
			left_above_q <= above;
		end else if (take && kind_q == PT_COPY) begin
			busy_q <= 1'b0;
		end else if (take) begin
			kind_q <= next_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_s2    <= job.row;
			col_s2    <= job.col;
			endg_s2   <= job.endg;
			centre_s2 <= sample_t'(sum4 >>> 2);
			vert_s2   <= sample_t'(sum_v >>> 1);
			horiz_s2  <= sample_t'(sum_h >>> 1);
			copy_s2   <= job.cur;
		end
	end

	assign row_even = IDX_W'({row_s2, 1'b0});
	assign col_even = IDX_W'({col_s2, 1'b0});

	assign points.valid = busy_q;

	always_comb begin
		unique case (kind_q)
			PT_CENTRE: begin
				points.out_row = row_even - IDX_W'(1);
				points.out_col = col_even - IDX_W'(1);
				points.value   = centre_s2;
			end
			PT_VERT: begin
				points.out_row = row_even - IDX_W'(1);
				points.out_col = col_even;
				points.value   = vert_s2;
			end
			PT_HORIZ: begin
				points.out_row = row_even;
				points.out_col = col_even - IDX_W'(1);
				points.value   = horiz_s2;
			end
			PT_COPY: begin
				points.out_row = row_even;
				points.out_col = col_even;
				points.value   = copy_s2;
			end
			default: begin
				points.out_row = row_even;
				points.out_col = col_even;
				points.value   = copy_s2;
			end
		endcase
	end

	assign points.last_of_run = (kind_q == PT_COPY);
	assign points.end_of_grid = (kind_q == PT_COPY) && endg_s2;

endmodule

// File: rtl/core/gup2x_checker.sv
// port-level checks of the upsampler output stream, bound to the top level
module gup2x_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input gup2x_pkg::idx_t     out_row,
	input gup2x_pkg::idx_t     out_col,
	input gup2x_pkg::sample_t  value,
	input logic                last_of_run,
	input logic                end_of_grid
);

	// a stalled point stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point dropped while stalled");

	// a stalled point keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) &&
			$stable(value) && $stable(last_of_run) && $stable(end_of_grid))
		else $error("point payload changed while stalled");

	// the grid ends on the copy point of a run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_grid |-> last_of_run)
		else $error("end of grid not on last point of run");

	// the last point of a run is the copied sample on an even position
	a_last_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> !out_row[0] && !out_col[0])
		else $error("last point of run not on even position");

endmodule

bind grid_upsample_2x_midpoint gup2x_checker u_gup2x_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (points.valid),
	.out_ready   (points.ready),
	.out_row     (points.out_row),
	.out_col     (points.out_col),
	.value       (points.value),
	.last_of_run (points.last_of_run),
	.end_of_grid (points.end_of_grid)
);

// File: dv/grid_upsample_2x_midpoint_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the 2x midpoint grid upsampler: random grids, stalls, sizes
module grid_upsample_2x_midpoint_tb;
	import gup2x_pkg::*;

	// idle cycles with no item on any channel before the run is called hung
	localparam int STALL_LIMIT = 2000;
	// length of the long receiver hold-off that backs the block up
	localparam int HOLD_CYCLES = 300;
	// register indexes past the end of the register list, writes are dropped
	localparam cfg_idx_t REG_SPARE_2 = cfg_idx_t'(2);
	localparam cfg_idx_t REG_SPARE_3 = cfg_idx_t'(3);

	// one expected output point
	typedef struct packed {
		idx_t    row;
		idx_t    col;
		sample_t value;
		logic    last;
		logic    endg;
	} grid_point_t;

	logic clk;
	logic arst_n = 1'b0;

	// all block inputs start at known values
	logic     in_valid  = 1'b0;
	sample_t  in_sample = '0;
	logic     pt_ready  = 1'b0;
	logic     cfg_valid = 1'b0;
	cfg_idx_t cfg_index = REG_SOURCE_ROWS;
	dim_t     cfg_data  = '0;

	gup2x_in_if  samples_if ();
	gup2x_out_if points_if ();
	gup2x_cfg_if cfg_if ();

	assign samples_if.valid  = in_valid;
	assign samples_if.sample = in_sample;
	assign points_if.ready   = pt_ready;
	assign cfg_if.valid      = cfg_valid;
	assign cfg_if.index      = cfg_index;
	assign cfg_if.data       = cfg_data;

	grid_upsample_2x_midpoint dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.points (points_if),
		.cfg    (cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// upsampler model: register copies, grid cursor, left neighbors, line store
	// ---------------------------------------------------------------
	dim_t        cfg_rows = dim_t'(5);
	dim_t        cfg_cols = dim_t'(17);
	int unsigned grid_row = 0;
	int unsigned grid_col = 0;
	sample_t     left_val = '0;
	sample_t     left_above_val = '0;
	sample_t     line_mem [MAX_COLS] = '{default: '0};

	grid_point_t due_points [$];
	sample_t     pending_samples [$];

	int          errors = 0;
	int unsigned samples_queued = 0;
	int unsigned samples_accepted = 0;
	int unsigned idle_cycles = 0;

	// handshake flags passed from the sampling edge to the driving edge
	bit          sample_taken = 0;
	bit          point_taken = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	int unsigned hold_token = 0;
	int unsigned hold_seen = 0;
	bit          no_idle = 0;

	// register value to the size actually used, out of range values clamp
	function automatic int unsigned effective_dim(dim_t v, int unsigned maxv);
		if (v < 2)
			return 2;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// a write to either size register restarts the grid, spare indexes do nothing
	function automatic void apply_reg_write(cfg_idx_t idx, dim_t val);
		case (idx)
			REG_SOURCE_ROWS: begin
				cfg_rows = val;
				grid_row = 0;
				grid_col = 0;
			end
			REG_SOURCE_COLS: begin
				cfg_cols = val;
				grid_row = 0;
				grid_col = 0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void push_point(int unsigned r, int unsigned c, sample_t v,
		logic last, logic endg);
		grid_point_t p;
		p.row   = idx_t'(r);
		p.col   = idx_t'(c);
		p.value = v;
		p.last  = last;
		p.endg  = endg;
		due_points.push_back(p);
	endfunction

	// expected points for one source sample, in emission order:
	// centre, vertical, horizontal, copy; points off the grid edge are skipped
	function automatic void predict_points(sample_t cur);
		int unsigned         nr;
		int unsigned         nc;
		int unsigned         r;
		int unsigned         c;
		sample_t             above;
		logic signed [17:0]  sum;
		logic                endg;
		nr = effective_dim(cfg_rows, MAX_ROWS);
		nc = effective_dim(cfg_cols, MAX_COLS);
		r = grid_row;
		c = grid_col;
		if (r >= nr || c >= nc) begin
			r = 0;
			c = 0;
		end
		above = line_mem[c];
		endg = (r == nr - 1) && (c == nc - 1);
		// arithmetic shift gives floor rounding for negative sums too
		if (r > 0 && c > 0) begin
			sum = left_above_val + above + left_val + cur;
			push_point(2 * r - 1, 2 * c - 1, sample_t'(sum >>> 2), 1'b0, 1'b0);
		end
		if (r > 0) begin
			sum = above + cur;
			push_point(2 * r - 1, 2 * c, sample_t'(sum >>> 1), 1'b0, 1'b0);
		end
		if (c > 0) begin
			sum = left_val + cur;
			push_point(2 * r, 2 * c - 1, sample_t'(sum >>> 1), 1'b0, 1'b0);
		end
		push_point(2 * r, 2 * c, cur, 1'b1, endg);
		left_above_val = above;
		left_val = cur;
		line_mem[c] = cur;
		// end of a row moves down, end of the grid wraps to a new grid
		if (c + 1 >= nc) begin
			grid_col = 0;
			grid_row = (r + 1 >= nr) ? 0 : r + 1;
		end else begin
			grid_col = c + 1;
			grid_row = r;
		end
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------
	// sampling edge: register writes, accepted samples, checked points, watchdog
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		bit          progress;
		grid_point_t want;
		if (arst_n) begin
			progress = 0;
			if (cfg_valid && cfg_if.ready) begin
				apply_reg_write(cfg_index, cfg_data);
				progress = 1;
			end
			if (in_valid && samples_if.ready) begin
				predict_points(in_sample);
				samples_accepted++;
				sample_taken = 1;
				progress = 1;
			end
			if (points_if.valid && pt_ready) begin
				point_taken = 1;
				progress = 1;
				if (due_points.size() == 0) begin
					$display("%0t: unexpected point, row %0d col %0d value %0d", $time,
						points_if.out_row, points_if.out_col, points_if.value);
					errors++;
				end else begin
					want = due_points.pop_front();
					compare_field("out_row", want.row, points_if.out_row);
					compare_field("out_col", want.col, points_if.out_col);
					compare_field("value", want.value, points_if.value);
					compare_field("last_of_run", want.last, points_if.last_of_run);
					compare_field("end_of_grid", want.endg, points_if.end_of_grid);
				end
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// sample driver: pops pending samples, random gap after each accepted item
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		logic offer;
		if (arst_n) begin
			offer = in_valid;
			if (sample_taken) begin
				sample_taken = 0;
				offer = 1'b0;
				gap_left = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (!offer) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_samples.size() > 0) begin
					offer = 1'b1;
					in_sample <= pending_samples.pop_front();
				end
			end
			// one assignment per edge, so a back-to-back item keeps valid high
			in_valid <= offer;
		end
	end

	// ---------------------------------------------------------------
	// point receiver: random stall after each item unless no_idle is set, plus a long hold on request
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (point_taken) begin
				point_taken = 0;
				stall_left = no_idle ? 0 : $urandom_range(0, 9);
			end
			if (hold_left > 0) begin
				hold_left--;
				pt_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pt_ready <= 1'b0;
			end else begin
				pt_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic push_sample(sample_t v);
		pending_samples.push_back(v);
		samples_queued++;
	endtask

	// random content, with the range ends and values around zero now and then
	task automatic queue_random(int unsigned n);
		@(posedge clk);
		repeat (n) begin
			case ($urandom_range(0, 11))
				0: push_sample(16'sh7fff);
				1: push_sample(16'sh8000);
				2: push_sample(16'shffff);
				3: push_sample(sample_t'($urandom_range(0, 3)));
				default: push_sample(sample_t'($urandom));
			endcase
		end
	endtask

	// sender holds back until every sample is in and every point is out,
	// then idles on to let the pipeline drain
	task automatic wait_idle();
		@(negedge clk);
		while (samples_accepted != samples_queued || due_points.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_reg(cfg_idx_t idx, dim_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic dim_t pick_rows();
		case ($urandom_range(0, 11))
			0: return dim_t'(0);
			1: return dim_t'(1);
			2: return dim_t'(2047);
			3: return dim_t'(1024);
			default: return dim_t'($urandom_range(2, 6));
		endcase
	endfunction

	function automatic dim_t pick_cols();
		case ($urandom_range(0, 11))
			0: return dim_t'(1);
			1: return dim_t'(0);
			2: return dim_t'(1024);
			3: return dim_t'(2047);
			4: return dim_t'(1025);
			default: return dim_t'($urandom_range(2, 16));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned grid_size;
		int unsigned n;
		int unsigned half;
		dim_t        rows_val;
		dim_t        cols_val;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes 5 by 17: a few samples on the first row
		@(posedge clk);
		push_sample(16'sh7fff);
		push_sample(16'sh8000);
		push_sample(16'sh0001);
		wait_idle();

		// smallest grid, range ends, floor of a negative odd sum
		write_reg(REG_SOURCE_ROWS, dim_t'(2));
		write_reg(REG_SOURCE_COLS, dim_t'(2));
		@(posedge clk);
		push_sample(16'sh7fff);
		push_sample(16'sh8000);
		push_sample(16'sh8000);
		push_sample(16'shffff);
		wait_idle();

		// 3 by 3 grid; spare register writes halfway must not restart it
		write_reg(REG_SOURCE_ROWS, dim_t'(3));
		write_reg(REG_SOURCE_COLS, dim_t'(3));
		@(posedge clk);
		push_sample(16'sh0001);
		push_sample(16'shffff);
		push_sample(16'sh0000);
		push_sample(16'sh8000);
		wait_idle();
		write_reg(REG_SPARE_2, dim_t'(2047));
		write_reg(REG_SPARE_3, dim_t'(0));
		@(posedge clk);
		push_sample(16'sh7fff);
		push_sample(16'sh7fff);
		push_sample(16'sh8001);
		push_sample(16'shfffe);
		push_sample(16'sh0003);
		// past the end of the grid the cursor wraps to a new grid
		push_sample(16'sh8000);
		push_sample(16'sh7fff);
		push_sample(16'sh8000);
		wait_idle();

		// random phases: new sizes, then whole grids, a few cut short
		random_items = 0;
		phase = 0;
		while (random_items < 330) begin
			rows_val = pick_rows();
			cols_val = pick_cols();
			case ($urandom_range(0, 5))
				0: write_reg(REG_SOURCE_ROWS, rows_val);
				1: write_reg(REG_SOURCE_COLS, cols_val);
				2: begin
					write_reg(REG_SOURCE_COLS, cols_val);
					write_reg(REG_SOURCE_ROWS, rows_val);
				end
				default: begin
					write_reg(REG_SOURCE_ROWS, rows_val);
					write_reg(REG_SOURCE_COLS, cols_val);
				end
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, dim_t'($urandom));

			grid_size = effective_dim(cfg_rows, MAX_ROWS) * effective_dim(cfg_cols, MAX_COLS);
			if (grid_size > 120)
				n = $urandom_range(20, 60);
			else if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, grid_size - 1);
			else
				n = grid_size * $urandom_range(1, 2);
			if (n > 120)
				n = 120;
			no_idle = ($urandom_range(0, 4) == 0);

			if (phase == 1) begin
				// receiver holds off long while the sender keeps offering
				if (n < 40)
					n = 40;
				no_idle = 0;
				hold_token++;
				queue_random(n);
			end else if (phase == 3) begin
				// sender pauses halfway through the phase until every point has come out
				half = n / 2;
				queue_random(half);
				wait_idle();
				queue_random(n - half);
			end else begin
				queue_random(n);
			end
			wait_idle();
			random_items += n;
			phase++;
		end

		// extreme sizes written once more before the end
		write_reg(REG_SOURCE_ROWS, dim_t'(1024));
		write_reg(REG_SOURCE_COLS, dim_t'(2));
		no_idle = 0;
		queue_random(12);
		wait_idle();

		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
